@@ rtl/core/pbcst_pkg.sv @@
package pbcst_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_BOX_XX   = 3'd0,
		CFG_BOX_YX   = 3'd1,
		CFG_BOX_YY   = 3'd2,
		CFG_BOX_ZX   = 3'd3,
		CFG_BOX_ZY   = 3'd4,
		CFG_BOX_ZZ   = 3'd5,
		CFG_PBC_DIMS = 3'd6
	} pbcst_cfg_idx_t;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 32;
	localparam int unsigned CoordW   = 32;
	localparam int unsigned DiagW    = 31;
	localparam int unsigned ShiftW   = 8;
	localparam int unsigned IndexW   = 10;

	// Controller to datapath
	typedef struct packed {
		logic clear;   // write one zero entry of the shift store
		logic load;    // capture a new beat, start the store read
		logic start;   // take the shifts, set up the first dimension
		logic step;    // one correction or dimension advance
		logic finish;  // write back shifts, fill the result register
	} pbcst_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;  // clearing pass is on its last entry
		logic no_dims;   // no periodic dimension configured
		logic dim_done;  // current dimension is in range or at the wrap limit
		logic last_dim;  // current dimension is x
		logic out_free;  // result register can take a new beat
	} pbcst_status_t;

endpackage

@@ rtl/core/pbcst_ctrl.sv @@
module pbcst_ctrl
	import pbcst_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pbcst_status_t st,
	output pbcst_cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_READ  = 5'b00100,
		S_WRAP  = 5'b01000,
		S_DONE  = 5'b10000
	} pbcst_state_t;

	pbcst_state_t state_q, state_d;

	// Command decode
	always_comb begin
		cmd        = '0;
		cmd.clear  = (state_q == S_CLEAR);
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.start  = (state_q == S_READ);
		cmd.step   = (state_q == S_WRAP);
		cmd.finish = (state_q == S_DONE) && st.out_free;
	end

	assign in_ready = (state_q == S_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_READ;
			end
			S_READ: begin
				state_d = st.no_dims ? S_DONE : S_WRAP;
			end
			S_WRAP: begin
				if (st.dim_done && st.last_dim) state_d = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Checks
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_READ))
		else $error("accepted beat did not start a store read");

	a_last_dim_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRAP && st.dim_done && st.last_dim) |=> (state_q == S_DONE))
		else $error("last dimension finished without moving to write-back");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> st.out_free)
		else $error("result written while result register busy");

endmodule

@@ rtl/core/pbcst_dp.sv @@
module pbcst_dp
	import pbcst_pkg::*;
#(
	parameter int unsigned ATOM_COUNT = 1024,
	parameter int unsigned MAX_WRAPS  = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_we,
	input  logic [CfgIdxW-1:0]        cfg_index,
	input  logic [CfgDataW-1:0]       cfg_data,
	// input beat
	input  logic [IndexW-1:0]         atom_index,
	input  logic signed [CoordW-1:0]  cur_x,
	input  logic signed [CoordW-1:0]  cur_y,
	input  logic signed [CoordW-1:0]  cur_z,
	input  logic signed [CoordW-1:0]  ref_x,
	input  logic signed [CoordW-1:0]  ref_y,
	input  logic signed [CoordW-1:0]  ref_z,
	// result beat
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [ShiftW-1:0]  shift_x,
	output logic signed [ShiftW-1:0]  shift_y,
	output logic signed [ShiftW-1:0]  shift_z,
	output logic signed [CoordW-1:0]  wrapped_dx,
	output logic signed [CoordW-1:0]  wrapped_dy,
	output logic signed [CoordW-1:0]  wrapped_dz,
	output logic                      limit_hit,
	// control
	input  pbcst_cmd_t                cmd,
	output pbcst_status_t             st
);

	localparam int unsigned AW  = (ATOM_COUNT > 1) ? $clog2(ATOM_COUNT) : 1;
	localparam int unsigned NW  = $clog2(MAX_WRAPS + 1);
	// displacement: 33-bit difference plus up to 3*MAX_WRAPS box rows
	localparam int unsigned DW  = CoordW + 2 + $clog2(3 * MAX_WRAPS);
	localparam int unsigned XW  = 17;  // wide enough for ATOM_COUNT up to 2**17 - 1
	localparam int unsigned EW  = 3 * ShiftW;
	localparam logic signed [ShiftW-1:0] SMax = {1'b0, {(ShiftW-1){1'b1}}};
	localparam logic signed [ShiftW-1:0] SMin = {1'b1, {(ShiftW-1){1'b0}}};

	// Configuration registers
	logic        [DiagW-1:0]    box_xx_q, box_yy_q, box_zz_q;
	logic signed [CoordW-1:0]   box_yx_q, box_zx_q, box_zy_q;
	logic        [1:0]          pbc_dims_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_xx_q   <= DiagW'(4194304);
			box_yx_q   <= '0;
			box_yy_q   <= DiagW'(4194304);
			box_zx_q   <= '0;
			box_zy_q   <= '0;
			box_zz_q   <= DiagW'(4194304);
			pbc_dims_q <= 2'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BOX_XX:   box_xx_q   <= cfg_data[DiagW-1:0];
				CFG_BOX_YX:   box_yx_q   <= cfg_data;
				CFG_BOX_YY:   box_yy_q   <= cfg_data[DiagW-1:0];
				CFG_BOX_ZX:   box_zx_q   <= cfg_data;
				CFG_BOX_ZY:   box_zy_q   <= cfg_data;
				CFG_BOX_ZZ:   box_zz_q   <= cfg_data[DiagW-1:0];
				CFG_PBC_DIMS: pbc_dims_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Shift store with clearing pass and registered read
	logic [EW-1:0] mem [ATOM_COUNT];
	logic [EW-1:0] rd_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] addr_q;
	logic          idx_ok_q;
	logic [XW-1:0] idx_ext;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	logic          wr_en;

	logic signed [ShiftW-1:0] s_q [3];
	logic signed [DW-1:0]     d_q [3];
	logic [NW-1:0]            n_q;
	logic [1:0]               m_q;
	logic                     flag_q;

	assign idx_ext = {{(XW-IndexW){1'b0}}, atom_index};
	assign wr_en   = cmd.clear || (cmd.finish && idx_ok_q);
	assign wr_addr = cmd.clear ? clr_q : addr_q;
	assign wr_data = cmd.clear ? '0 : {s_q[2], s_q[1], s_q[0]};

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.load) rd_q <= mem[idx_ext[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// Row of the current dimension and the half-box tests
	logic        [DiagW-1:0]  diag;
	logic signed [DW-1:0]     row [3];
	logic signed [DW-1:0]     dm;
	logic signed [DW:0]       d2, diag_s, diag_n;
	logic signed [ShiftW-1:0] sm;
	logic                     lo, hi, lim, dim_done, sat;

	always_comb begin
		diag   = '0;
		row[0] = '0;
		row[1] = '0;
		row[2] = '0;
		dm     = '0;
		sm     = '0;
		unique case (m_q)
			2'd0: begin
				diag   = box_xx_q;
				row[0] = {{(DW-DiagW){1'b0}}, box_xx_q};
				dm     = d_q[0];
				sm     = s_q[0];
			end
			2'd1: begin
				diag   = box_yy_q;
				row[0] = {{(DW-CoordW){box_yx_q[CoordW-1]}}, box_yx_q};
				row[1] = {{(DW-DiagW){1'b0}}, box_yy_q};
				dm     = d_q[1];
				sm     = s_q[1];
			end
			2'd2: begin
				diag   = box_zz_q;
				row[0] = {{(DW-CoordW){box_zx_q[CoordW-1]}}, box_zx_q};
				row[1] = {{(DW-CoordW){box_zy_q[CoordW-1]}}, box_zy_q};
				row[2] = {{(DW-DiagW){1'b0}}, box_zz_q};
				dm     = d_q[2];
				sm     = s_q[2];
			end
			default: ;
		endcase
		d2       = {dm, 1'b0};
		diag_s   = {{(DW+1-DiagW){1'b0}}, diag};
		diag_n   = -diag_s;
		lo       = d2 < diag_n;
		hi       = d2 >= diag_s;
		lim      = (n_q == NW'(MAX_WRAPS));
		dim_done = !(lo || hi) || lim;
		sat      = (lo && sm == SMax) || (hi && sm == SMin);
	end

	// Displacement, shifts and wrap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			m_q    <= '0;
			flag_q <= 1'b0;
		end else if (cmd.start) begin
			n_q    <= '0;
			m_q    <= pbc_dims_q - 2'd1;
			flag_q <= 1'b0;
		end else if (cmd.step) begin
			if (dim_done) begin
				if (lo || hi) flag_q <= 1'b1;
				if (m_q != 2'd0) begin
					m_q <= m_q - 2'd1;
					n_q <= '0;
				end
			end else begin
				n_q <= n_q + NW'(1);
				if (sat) flag_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q   <= idx_ext[AW-1:0];
			idx_ok_q <= (idx_ext < XW'(ATOM_COUNT));
			d_q[0]   <= {{(DW-CoordW){cur_x[CoordW-1]}}, cur_x}
				- {{(DW-CoordW){ref_x[CoordW-1]}}, ref_x};
			d_q[1]   <= {{(DW-CoordW){cur_y[CoordW-1]}}, cur_y}
				- {{(DW-CoordW){ref_y[CoordW-1]}}, ref_y};
			d_q[2]   <= {{(DW-CoordW){cur_z[CoordW-1]}}, cur_z}
				- {{(DW-CoordW){ref_z[CoordW-1]}}, ref_z};
		end else if (cmd.start) begin
			// an index past the store works from zero shifts
			s_q[0] <= idx_ok_q ? rd_q[ShiftW-1:0]        : '0;
			s_q[1] <= idx_ok_q ? rd_q[2*ShiftW-1:ShiftW] : '0;
			s_q[2] <= idx_ok_q ? rd_q[EW-1:2*ShiftW]     : '0;
		end else if (cmd.step && !dim_done) begin
			for (int k = 0; k < 3; k++) begin
				d_q[k] <= lo ? d_q[k] + row[k] : d_q[k] - row[k];
			end
			if (!sat) s_q[m_q] <= lo ? sm + ShiftW'(1) : sm - ShiftW'(1);
		end
	end

	// Clamp a displacement to the 32-bit output range
	function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [DW-1:0] v);
		logic hi_ok;
		hi_ok = (v[DW-1:CoordW-1] == '0) || (v[DW-1:CoordW-1] == '1);
		if (hi_ok) sat_coord = v[CoordW-1:0];
		else if (v[DW-1]) sat_coord = {1'b1, {(CoordW-1){1'b0}}};
		else sat_coord = {1'b0, {(CoordW-1){1'b1}}};
	endfunction

	// Result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			shift_x    <= s_q[0];
			shift_y    <= s_q[1];
			shift_z    <= s_q[2];
			wrapped_dx <= sat_coord(d_q[0]);
			wrapped_dy <= sat_coord(d_q[1]);
			wrapped_dz <= sat_coord(d_q[2]);
			limit_hit  <= flag_q;
		end
	end

	assign out_valid = out_valid_q;

	// Status
	assign st.clr_last = (clr_q == AW'(ATOM_COUNT - 1));
	assign st.no_dims  = (pbc_dims_q == 2'd0);
	assign st.dim_done = dim_done;
	assign st.last_dim = (m_q == 2'd0);
	assign st.out_free = !out_valid_q || out_ready;

	// Checks
	a_wrap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(MAX_WRAPS))
		else $error("wrap counter passed its limit");

	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished item did not raise result valid");

	a_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && flag_q) |=> flag_q)
		else $error("limit flag dropped during corrections");

endmodule

@@ rtl/core/pbc_shift_tracker.sv @@
// Periodic image-shift tracker for a triclinic box. Each input beat carries an
// atom index and a current and reference position (signed Q11.20 nm); the block
// forms cur - ref, then from the highest periodic dimension down adds or
// subtracts the box row until that component lies in [-box/2, +box/2), counting
// the atom's stored image shift up or down per correction, and returns the new
// shifts, the wrapped displacement (clamped to 32 bits) and limit_hit when a
// dimension needs more than MAX_WRAPS corrections or a shift count saturates.
// Per item: load, store read, each periodic dimension in turn (up to MAX_WRAPS
// box corrections each), write-back; all three components take each box-row
// correction at once, one correction per cycle, and a dimension ends on a step
// finding it in range or at the limit. A result waiting in the output register
// does not stop the next beat from being taken. After reset the shift store is
// cleared, one entry per cycle, in_ready low until all ATOM_COUNT entries are
// zero; configuration writes are taken throughout. The user is to write the box
// registers via cfg_we / cfg_index / cfg_data only while idle, unenforced.
module pbc_shift_tracker
	import pbcst_pkg::*;
#(
	parameter int unsigned ATOM_COUNT = 1024,
	parameter int unsigned MAX_WRAPS  = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CfgIdxW-1:0]        cfg_index,
	input  logic [CfgDataW-1:0]       cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [IndexW-1:0]         atom_index,
	input  logic signed [CoordW-1:0]  cur_x,
	input  logic signed [CoordW-1:0]  cur_y,
	input  logic signed [CoordW-1:0]  cur_z,
	input  logic signed [CoordW-1:0]  ref_x,
	input  logic signed [CoordW-1:0]  ref_y,
	input  logic signed [CoordW-1:0]  ref_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [ShiftW-1:0]  shift_x,
	output logic signed [ShiftW-1:0]  shift_y,
	output logic signed [ShiftW-1:0]  shift_z,
	output logic signed [CoordW-1:0]  wrapped_dx,
	output logic signed [CoordW-1:0]  wrapped_dy,
	output logic signed [CoordW-1:0]  wrapped_dz,
	output logic                      limit_hit
);

	pbcst_cmd_t    cmd;
	pbcst_status_t st;

	pbcst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	pbcst_dp #(
		.ATOM_COUNT (ATOM_COUNT),
		.MAX_WRAPS  (MAX_WRAPS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.atom_index (atom_index),
		.cur_x      (cur_x),
		.cur_y      (cur_y),
		.cur_z      (cur_z),
		.ref_x      (ref_x),
		.ref_y      (ref_y),
		.ref_z      (ref_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.shift_x    (shift_x),
		.shift_y    (shift_y),
		.shift_z    (shift_z),
		.wrapped_dx (wrapped_dx),
		.wrapped_dy (wrapped_dy),
		.wrapped_dz (wrapped_dz),
		.limit_hit  (limit_hit),
		.cmd        (cmd),
		.st         (st)
	);

endmodule
